### design/lcs_pkg.sv
// lcs_pkg: request, result and command types and constants of the led cube layer scanner
`default_nettype none
package lcs_pkg;

	localparam int unsigned LAYER_W = 3;
	localparam int unsigned ROW_W   = 3;
	localparam int unsigned VOXELS  = 64;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [ROW_W-1:0] TOP_ROW    = 3'd7;
	localparam logic [ROW_W-1:0] BOTTOM_ROW = 3'd0;
	localparam logic [7:0]       SEL_ONE    = 8'h01;
	localparam logic [15:0]      DIV_RESET  = 16'd10;

	typedef struct packed {
		logic               kind;
		logic [LAYER_W-1:0] write_layer;
		logic [ROW_W-1:0]   write_row;
		logic [7:0]         row_bits;
	} item_t;

	typedef struct packed {
		logic [7:0] shift_byte;
		logic       clear_before;
		logic       is_layer_select;
		logic       last_of_frame;
	} result_t;

	// command passed from front to back
	typedef struct packed {
		logic               is_write;
		logic [LAYER_W-1:0] layer;
		logic [ROW_W-1:0]   row;
		logic [7:0]         bits;
	} cmd_t;

endpackage
`default_nettype wire

### design/lcs_fifo.sv
// lcs_fifo: small register queue used for commands and for results
`default_nettype none
module lcs_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter type item_t = logic
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire item_t                      din,
	output logic                            full,
	input  wire logic                       pop,
	output item_t                           dout,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH+1);

	item_t          slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count beyond depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty fifo with unequal pointers");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not lower the count");

endmodule
`default_nettype wire

### design/lcs_front.sv
// lcs_front: takes requests, keeps divider, tick count and layer, issues commands
`default_nettype none
module lcs_front #(
	parameter int unsigned LAYERS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lcs_pkg::item_t item,
	output logic                full,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_data,
	output logic                cmd_push,
	output lcs_pkg::cmd_t       cmd,
	input  wire logic           cmd_full
);

	logic [15:0]                  divider_q;
	logic [15:0]                  tick_q;
	logic [lcs_pkg::LAYER_W-1:0]  layer_q;
	logic [15:0]                  tick_next;
	logic                         accept;
	logic                         is_write;
	logic                         refresh;

	assign full      = cmd_full;
	assign accept    = push && !cmd_full;
	assign is_write  = (item.kind == lcs_pkg::KIND_WRITE);
	assign tick_next = tick_q + 16'd1;
	assign refresh   = !is_write && (tick_next >= divider_q);
	assign cmd_push  = accept && (is_write || refresh);

	always_comb begin
		cmd.is_write = is_write;
		cmd.layer    = is_write ? item.write_layer : layer_q;
		cmd.row      = item.write_row;
		cmd.bits     = item.row_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= lcs_pkg::DIV_RESET;
			tick_q    <= '0;
			layer_q   <= '0;
		end else begin
			if (cfg_we) begin
				divider_q <= cfg_data;
			end
			if (accept && !is_write) begin
				if (refresh) begin
					tick_q  <= '0;
					// wrap the scan at the top layer
					layer_q <= (layer_q == lcs_pkg::LAYER_W'(LAYERS-1)) ? '0 : layer_q + 1'b1;
				end else begin
					tick_q <= tick_next;
				end
			end
		end
	end

	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		layer_q <= lcs_pkg::LAYER_W'(LAYERS-1))
		else $error("layer index past the top layer");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");
	a_refresh_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && refresh) |=> (tick_q == '0))
		else $error("tick count not cleared on refresh");

endmodule
`default_nettype wire

### design/lcs_back.sv
// lcs_back: voxel store and layer scan sequencer feeding the result queue
`default_nettype none
module lcs_back #(
	parameter int unsigned OUT_DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lcs_pkg::cmd_t                  cmd,
	input  wire logic                           cmd_empty,
	output logic                                cmd_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                                res_push,
	output lcs_pkg::result_t                    res
);

	localparam int unsigned CW = $clog2(OUT_DEPTH+1);
	localparam int unsigned AW = lcs_pkg::LAYER_W + lcs_pkg::ROW_W;

	typedef enum logic {S_IDLE, S_ROWS} state_t;

	state_t                       state_q;
	logic [lcs_pkg::LAYER_W-1:0]  layer_q;
	logic [lcs_pkg::ROW_W-1:0]    row_q;
	logic [7:0]                   mem_q [lcs_pkg::VOXELS];
	logic [lcs_pkg::VOXELS-1:0]   written_q;

	logic                         vld_s1;
	logic                         sel_s1;
	logic                         last_s1;
	logic [7:0]                   sel_byte_s1;
	logic [7:0]                   rd_data_s1;
	logic                         rd_ok_s1;

	logic                         space;
	logic                         start_sel;
	logic                         issue_row;
	logic                         do_write;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;

	// s1 holds a result slot already claimed in the queue
	assign space = ({1'b0, out_count} + (CW+1)'(vld_s1)) < (CW+1)'(OUT_DEPTH);

	always_comb begin
		start_sel = 1'b0;
		issue_row = 1'b0;
		do_write  = 1'b0;
		cmd_pop   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.is_write) begin
						do_write = 1'b1;
						cmd_pop  = 1'b1;
					end else if (space) begin
						start_sel = 1'b1;
						cmd_pop   = 1'b1;
					end
				end
			end
			S_ROWS: begin
				issue_row = space;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = {cmd.layer, cmd.row};
	assign rd_addr = {layer_q, row_q};

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[wr_addr] <= cmd.bits;
		end
		rd_data_s1  <= mem_q[rd_addr];
		sel_byte_s1 <= lcs_pkg::SEL_ONE << cmd.layer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			layer_q   <= '0;
			row_q     <= lcs_pkg::TOP_ROW;
			written_q <= '0;
			vld_s1    <= 1'b0;
			sel_s1    <= 1'b0;
			last_s1   <= 1'b0;
			rd_ok_s1  <= 1'b0;
		end else begin
			vld_s1   <= start_sel || issue_row;
			sel_s1   <= start_sel;
			last_s1  <= issue_row && (row_q == lcs_pkg::BOTTOM_ROW);
			rd_ok_s1 <= written_q[rd_addr];
			if (do_write) begin
				written_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start_sel) begin
						layer_q <= cmd.layer;
						row_q   <= lcs_pkg::TOP_ROW;
						state_q <= S_ROWS;
					end
				end
				S_ROWS: begin
					if (issue_row) begin
						row_q <= row_q - 1'b1;
						if (row_q == lcs_pkg::BOTTOM_ROW) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// rows never written read as dark
	always_comb begin
		res_push              = vld_s1;
		res.shift_byte        = sel_s1 ? sel_byte_s1 : (rd_ok_s1 ? rd_data_s1 : 8'h00);
		res.clear_before      = sel_s1;
		res.is_layer_select   = sel_s1;
		res.last_of_frame     = last_s1;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, out_count} + (CW+1)'(vld_s1)) <= (CW+1)'(OUT_DEPTH))
		else $error("result queue overcommitted");
	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && last_s1) |-> (state_q == S_IDLE))
		else $error("last row emitted while scan still running");
	a_sel_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		sel_s1 |-> (vld_s1 && !last_s1))
		else $error("layer select marked as last");

endmodule
`default_nettype wire

### design/led_cube_layer_scanner.sv
// led_cube_layer_scanner: top level joining front, command queue, back and result queue
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------
//  request   | push / full        | item   (kind, layer, row, bits)
//  result    | pop / empty        | result (byte and three flags)
//  config    | cfg_we             | cfg_data (refresh divider)
//
//  the front passes a write on combinationally; a tick without refresh only advances the tick count
//  a refresh emits nine results, a layer select and then the rows, read through the single
//  read port of the voxel store one row per cycle while the result queue has space
//  the command queue lets requests keep coming while a scan runs
//  a stalled result queue holds the scan; reset marks all voxels unwritten, so they read as dark
`default_nettype none
module led_cube_layer_scanner #(
	parameter int unsigned LAYERS    = 8,
	parameter int unsigned CMD_DEPTH = 2,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lcs_pkg::item_t   item,
	output logic                  full,
	input  wire logic             pop,
	output lcs_pkg::result_t      result,
	output logic                  empty,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data
);

	logic                           cmd_push;
	lcs_pkg::cmd_t                  cmd_in;
	logic                           cmd_full;
	lcs_pkg::cmd_t                  cmd_out;
	logic                           cmd_empty;
	logic                           cmd_pop;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic                           res_push;
	lcs_pkg::result_t               res;
	logic                           out_full;

	lcs_front #(.LAYERS(LAYERS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	lcs_fifo #(.DEPTH(CMD_DEPTH), .item_t(lcs_pkg::cmd_t)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	lcs_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (res)
	);

	lcs_fifo #(.DEPTH(OUT_DEPTH), .item_t(lcs_pkg::result_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty),
		.count  (out_count)
	);

	a_cmd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_count <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH))
		else $error("command queue count out of range");
	a_res_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("result pushed into a full queue");
	a_full_tracks_q: assert property (@(posedge clk) disable iff (!arst_n)
		full == cmd_full)
		else $error("request full differs from command queue");

endmodule
`default_nettype wire
